[rtl/bgps_pkg.sv]
// Shared types and constants of the gait phase sequencer.
package bgps_pkg;

  localparam int LEN_W     = 23;  // foot position word, 0.1 um
  localparam int ANG_W     = 29;  // foot angle word, microdegrees
  localparam int LIM_LEN_W = 16;  // per-tick length step limit
  localparam int LIM_ANG_W = 22;  // per-tick angle step limit
  localparam int TIME_W    = 32;  // phase timer, 1/25 us units
  localparam int STEP_W    = 16;

  localparam logic [TIME_W-1:0] T_SHORT  = 32'd10000000;  // 0.4 s
  localparam logic [TIME_W-1:0] T_LONG   = 32'd20000000;  // 0.8 s
  localparam logic [5:0]        ANG_RATE = 6'd60;         // udeg per us

  localparam logic [21:0] STAND_HEIGHT_RST   = 22'd1500000;
  localparam logic [19:0] STEP_LENGTH_RST    = 20'd300000;
  localparam logic [19:0] STEP_CLEAR_RST     = 20'd200000;
  localparam logic [26:0] TURN_ANGLE_RST     = 27'd10000000;
  localparam logic [25:0] BODY_TILT_RST      = 26'd8000000;
  localparam logic [16:0] RELEASE_LEVEL_RST  = 17'd300;
  localparam logic [7:0]  MOVE_SPEED_RST     = 8'd50;
  localparam logic signed [LEN_W-1:0] HEIGHT_RST = -23'sd1500000;

  typedef enum logic [2:0] {
    CMD_STOP   = 3'd0,
    CMD_FWD    = 3'd1,
    CMD_BACK   = 3'd2,
    CMD_TURN_L = 3'd3,
    CMD_TURN_R = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_STAND_HEIGHT  = 3'd0,
    CFG_STEP_LENGTH   = 3'd1,
    CFG_STEP_CLEAR    = 3'd2,
    CFG_TURN_ANGLE    = 3'd3,
    CFG_BODY_TILT     = 3'd4,
    CFG_RELEASE_LEVEL = 3'd5,
    CFG_MOVE_SPEED    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_STAND   = 3'd0,
    PH_SHIFT_L = 3'd1,
    PH_SWING_R = 3'd2,
    PH_DROP_R  = 3'd3,
    PH_SHIFT_R = 3'd4,
    PH_SWING_L = 3'd5,
    PH_DROP_L  = 3'd6
  } phase_t;

  typedef struct packed {
    logic signed [LEN_W-1:0] lx;
    logic signed [LEN_W-1:0] ly;
    logic signed [LEN_W-1:0] rx;
    logic signed [LEN_W-1:0] ry;
    logic signed [ANG_W-1:0] lyaw;
    logic signed [ANG_W-1:0] lroll;
    logic signed [ANG_W-1:0] ryaw;
    logic signed [ANG_W-1:0] rroll;
  } pose_t;

endpackage

[rtl/biped_gait_phase_sequencer_core.sv]
// Gait phase sequencer: seven-phase walking cycle with rate-limited foot poses.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  cfg     | in  | cfg_we                 | cfg_addr index, cfg_wdata value
//  in      | in  | in_tvalid / in_tready  | in_tdata: tick fields
//  out     | out | out_tvalid / out_tready| out_tdata: poses, phase, step count
//
// One tick per clock sustained while out_tready stays high. A tick is held in
// the input register, then the phase logic and eight rate limiters update the
// pose state, which is the result register. rst_n is synchronous: phase 0,
// timer and step count cleared, standing pose, registers back to their
// defaults. A stalled result holds its state and blocks the input register;
// the input side keeps taking a transfer while the input register is empty.
module biped_gait_phase_sequencer_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [26:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[2:0] dt_us[18:3] left_force[34:19] right_force[50:35]
  // left_grounded[51] right_grounded[52] zero[55:53]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_x[22:0] left_height[45:23] left_yaw[74:46] left_roll[103:75]
  // right_x[126:104] right_height[149:127] right_yaw[178:150]
  // right_roll[207:179] gait_phase[210:208] steps_taken[226:211] zero[231:227]
  output logic [231:0] out_tdata
);

  import bgps_pkg::*;

  // configuration
  logic [21:0] stand_height_r;
  logic [19:0] step_length_r;
  logic [19:0] step_clear_r;
  logic [26:0] turn_angle_r;
  logic [25:0] body_tilt_r;
  logic [16:0] release_level_r;
  logic [7:0]  move_speed_r;

  // input register
  logic        in_v_r;
  logic [2:0]  cmd_r;
  logic [15:0] dt_r;
  logic [15:0] lf_r;
  logic [15:0] rf_r;
  logic        lg_r;
  logic        rg_r;

  // sequencer state, also the result payload
  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   ptime_r, ptime_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  pose_t               pose_r, pose_nxt, tgt;
  logic                out_v_r;

  logic                fire;
  logic                moving;
  logic signed [LEN_W-1:0] sl, hsl, stand, lift;
  logic signed [ANG_W-1:0] tl, htl, tilt;
  logic [23:0]         adv;
  logic [TIME_W:0]     tsum;
  logic [TIME_W-1:0]   pt_adv;
  logic [LIM_ANG_W-1:0] lim_ang;

  assign fire       = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || fire;
  assign out_tvalid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stand_height_r  <= STAND_HEIGHT_RST;
      step_length_r   <= STEP_LENGTH_RST;
      step_clear_r    <= STEP_CLEAR_RST;
      turn_angle_r    <= TURN_ANGLE_RST;
      body_tilt_r     <= BODY_TILT_RST;
      release_level_r <= RELEASE_LEVEL_RST;
      move_speed_r    <= MOVE_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STAND_HEIGHT:  stand_height_r  <= cfg_wdata[21:0];
        CFG_STEP_LENGTH:   step_length_r   <= cfg_wdata[19:0];
        CFG_STEP_CLEAR:    step_clear_r    <= cfg_wdata[19:0];
        CFG_TURN_ANGLE:    turn_angle_r    <= cfg_wdata[26:0];
        CFG_BODY_TILT:     body_tilt_r     <= cfg_wdata[25:0];
        CFG_RELEASE_LEVEL: release_level_r <= cfg_wdata[16:0];
        CFG_MOVE_SPEED:    move_speed_r    <= cfg_wdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tdata[2:0];
      dt_r  <= in_tdata[18:3];
      lf_r  <= in_tdata[34:19];
      rf_r  <= in_tdata[50:35];
      lg_r  <= in_tdata[51];
      rg_r  <= in_tdata[52];
    end
  end

  // command decode: stride and turn targets, halves truncated in magnitude
  always_comb begin
    moving = 1'b1;
    sl     = '0;
    hsl    = '0;
    tl     = '0;
    htl    = '0;
    unique case (cmd_r)
      CMD_FWD: begin
        sl  = {3'b0, step_length_r};
        hsl = {4'b0, step_length_r[19:1]};
      end
      CMD_BACK: begin
        sl  = -{3'b0, step_length_r};
        hsl = -{4'b0, step_length_r[19:1]};
      end
      CMD_TURN_L: begin
        tl  = -{2'b0, turn_angle_r};
        htl = -{3'b0, turn_angle_r[26:1]};
      end
      CMD_TURN_R: begin
        tl  = {2'b0, turn_angle_r};
        htl = {3'b0, turn_angle_r[26:1]};
      end
      default: moving = 1'b0;  // stop and unknown codes
    endcase
  end

  assign stand = -{1'b0, stand_height_r};
  assign lift  = stand + {3'b0, step_clear_r};
  assign tilt  = {3'b0, body_tilt_r};

  // phase timer advance, saturating
  assign adv    = {8'b0, dt_r} * {16'b0, move_speed_r};
  assign tsum   = {1'b0, ptime_r} + {9'b0, adv};
  assign pt_adv = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    ptime_nxt = ptime_r;
    steps_nxt = steps_r;
    tgt       = '0;
    tgt.ly    = stand;
    tgt.ry    = stand;
    if (moving) begin
      ptime_nxt = pt_adv;
      unique case (phase_r)
        PH_SHIFT_L: begin
          tgt.lroll = tilt;  tgt.rroll = tilt;
          tgt.lx    = hsl;   tgt.rx    = -hsl;
          tgt.lyaw  = htl;   tgt.ryaw  = htl;
          if (pt_adv > T_SHORT && {1'b0, rf_r} < release_level_r) begin
            phase_nxt = PH_SWING_R;
            ptime_nxt = '0;
          end
        end
        PH_SWING_R: begin
          tgt.lroll = tilt;  tgt.rroll = tilt;
          tgt.lx    = -hsl;  tgt.rx    = sl;
          tgt.ryaw  = tl;    tgt.ry    = lift;
          if (pt_adv > T_SHORT) begin
            phase_nxt = PH_DROP_R;
            ptime_nxt = '0;
          end
        end
        PH_DROP_R: begin
          tgt.lroll = tilt;  tgt.rroll = tilt;
          tgt.lx    = -hsl;  tgt.rx    = sl;
          tgt.ryaw  = tl;
          if (rg_r || pt_adv > T_LONG) begin
            phase_nxt = PH_SHIFT_R;
            ptime_nxt = '0;
          end
        end
        PH_SHIFT_R: begin
          tgt.lroll = -tilt; tgt.rroll = -tilt;
          tgt.lx    = -hsl;  tgt.rx    = hsl;
          tgt.lyaw  = htl;   tgt.ryaw  = htl;
          if (pt_adv > T_SHORT && {1'b0, lf_r} < release_level_r) begin
            phase_nxt = PH_SWING_L;
            ptime_nxt = '0;
          end
        end
        PH_SWING_L: begin
          tgt.lroll = -tilt; tgt.rroll = -tilt;
          tgt.rx    = -hsl;  tgt.lx    = sl;
          tgt.lyaw  = tl;    tgt.ly    = lift;
          if (pt_adv > T_SHORT) begin
            phase_nxt = PH_DROP_L;
            ptime_nxt = '0;
          end
        end
        PH_DROP_L: begin
          tgt.lroll = -tilt; tgt.rroll = -tilt;
          tgt.rx    = -hsl;  tgt.lx    = sl;
          tgt.lyaw  = tl;
          if (lg_r || pt_adv > T_LONG) begin
            phase_nxt = PH_SHIFT_L;
            ptime_nxt = '0;
            steps_nxt = steps_r + 16'd1;
          end
        end
        default: begin
          // leave stand: enter shift left, still aim at the stand pose
          phase_nxt = PH_SHIFT_L;
          ptime_nxt = '0;
        end
      endcase
    end else begin
      phase_nxt = PH_STAND;
    end
  end

  assign lim_ang = {6'b0, dt_r} * {16'b0, ANG_RATE};

  bgps_slew #(.W(LEN_W), .LW(LIM_LEN_W)) u_slew_lx (
    .cur(pose_r.lx), .tgt(tgt.lx), .lim(dt_r), .nxt(pose_nxt.lx));
  bgps_slew #(.W(LEN_W), .LW(LIM_LEN_W)) u_slew_ly (
    .cur(pose_r.ly), .tgt(tgt.ly), .lim(dt_r), .nxt(pose_nxt.ly));
  bgps_slew #(.W(LEN_W), .LW(LIM_LEN_W)) u_slew_rx (
    .cur(pose_r.rx), .tgt(tgt.rx), .lim(dt_r), .nxt(pose_nxt.rx));
  bgps_slew #(.W(LEN_W), .LW(LIM_LEN_W)) u_slew_ry (
    .cur(pose_r.ry), .tgt(tgt.ry), .lim(dt_r), .nxt(pose_nxt.ry));
  bgps_slew #(.W(ANG_W), .LW(LIM_ANG_W)) u_slew_lyaw (
    .cur(pose_r.lyaw), .tgt(tgt.lyaw), .lim(lim_ang), .nxt(pose_nxt.lyaw));
  bgps_slew #(.W(ANG_W), .LW(LIM_ANG_W)) u_slew_lroll (
    .cur(pose_r.lroll), .tgt(tgt.lroll), .lim(lim_ang), .nxt(pose_nxt.lroll));
  bgps_slew #(.W(ANG_W), .LW(LIM_ANG_W)) u_slew_ryaw (
    .cur(pose_r.ryaw), .tgt(tgt.ryaw), .lim(lim_ang), .nxt(pose_nxt.ryaw));
  bgps_slew #(.W(ANG_W), .LW(LIM_ANG_W)) u_slew_rroll (
    .cur(pose_r.rroll), .tgt(tgt.rroll), .lim(lim_ang), .nxt(pose_nxt.rroll));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STAND;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptime_r  <= '0;
      steps_r  <= '0;
      pose_r   <= '{lx: '0, ly: HEIGHT_RST, rx: '0, ry: HEIGHT_RST,
                    lyaw: '0, lroll: '0, ryaw: '0, rroll: '0};
      out_v_r  <= 1'b0;
    end else begin
      if (fire) begin
        ptime_r <= ptime_nxt;
        steps_r <= steps_nxt;
        pose_r  <= pose_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tdata = {5'b0, steps_r, phase_r,
                      pose_r.rroll, pose_r.ryaw, pose_r.ry, pose_r.rx,
                      pose_r.lroll, pose_r.lyaw, pose_r.ly, pose_r.lx};

endmodule

[rtl/bgps_slew.sv]
// Rate limiter: move one pose value toward its target by at most lim.
module bgps_slew #(
  parameter int W  = 23,
  parameter int LW = 16
) (
  input  logic signed [W-1:0] cur,
  input  logic signed [W-1:0] tgt,
  input  logic        [LW-1:0] lim,
  output logic signed [W-1:0] nxt
);

  logic signed [W:0] diff;
  logic signed [W:0] lim_s;
  logic signed [W:0] up;
  logic signed [W:0] dn;

  assign lim_s = $signed({{(W + 1 - LW){1'b0}}, lim});
  assign diff  = $signed({tgt[W-1], tgt}) - $signed({cur[W-1], cur});
  assign up    = $signed({cur[W-1], cur}) + lim_s;
  assign dn    = $signed({cur[W-1], cur}) - lim_s;

  // result always lies between cur and tgt, so W bits hold it
  always_comb begin
    if (diff > lim_s) begin
      nxt = up[W-1:0];
    end else if (diff < -lim_s) begin
      nxt = dn[W-1:0];
    end else begin
      nxt = tgt;
    end
  end

endmodule

[sim/tb.sv]
// Self-checking testbench for the gait phase sequencer core.
`timescale 1ns / 1ps

module tb;
  import bgps_pkg::*;

  localparam int          N_DIRECTED         = 25;
  localparam int          RANDOM_PER_SETTING = 83;
  localparam int          HOLD_TICKS         = 257;
  localparam int          SETTINGS_RUN       = 6;
  localparam int          MAX_REPORTS        = 10;
  localparam int          TAIL_CYCLES        = 8;
  localparam int          WATCHDOG_LIMIT     = 2000;
  localparam logic [2:0]  CMD_UNUSED         = 3'd7;
  localparam logic [2:0]  CFG_UNUSED_IDX     = 3'd7;

  // Tick fields, lowest bits last in the declaration.
  typedef struct packed {
    logic        right_grounded;
    logic        left_grounded;
    logic [15:0] right_force;
    logic [15:0] left_force;
    logic [15:0] dt_us;
    logic [2:0]  cmd;
  } gait_tick_t;

  // Result fields as laid out in out_tdata[226:0].
  typedef struct packed {
    logic [STEP_W-1:0]       steps;
    logic [2:0]              phase;
    logic signed [ANG_W-1:0] rroll;
    logic signed [ANG_W-1:0] ryaw;
    logic signed [LEN_W-1:0] ry;
    logic signed [LEN_W-1:0] rx;
    logic signed [ANG_W-1:0] lroll;
    logic signed [ANG_W-1:0] lyaw;
    logic signed [LEN_W-1:0] ly;
    logic signed [LEN_W-1:0] lx;
  } gait_result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] dt_us;
    logic [15:0] left_force;
    logic [15:0] right_force;
    logic        left_grounded;
    logic        right_grounded;
    logic        typed;
    logic [2:0]  want_phase;
  } directed_row_t;

  typedef logic [6:0][26:0] reg_set_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [2:0]   cfg_addr   = '0;
  logic [26:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [231:0] out_tdata;

  biped_gait_phase_sequencer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predictor state starts at the reset values.
  logic [21:0] cfg_stand = STAND_HEIGHT_RST;
  logic [19:0] cfg_len   = STEP_LENGTH_RST;
  logic [19:0] cfg_clear = STEP_CLEAR_RST;
  logic [26:0] cfg_turn  = TURN_ANGLE_RST;
  logic [25:0] cfg_tilt  = BODY_TILT_RST;
  logic [16:0] cfg_rel   = RELEASE_LEVEL_RST;
  logic [7:0]  cfg_speed = MOVE_SPEED_RST;

  phase_t        model_phase = PH_STAND;
  logic [31:0]   model_timer = '0;
  logic [15:0]   model_steps = '0;
  longint        model_len [4] = '{0, longint'(HEIGHT_RST), 0, longint'(HEIGHT_RST)};
  longint        model_ang [4] = '{0, 0, 0, 0};

  gait_result_t  pending_poses [$];
  gait_result_t  mon_want;
  gait_result_t  mon_got;
  int            mismatch_count = 0;
  int            result_index   = 0;
  int            quiet_cycles   = 0;
  int            stall_left     = 0;
  bit            idle_on        = 1'b1;
  logic [2:0]    ep_cmd         = CMD_STOP;
  int            ep_left        = 0;

  // Walk stand, both feet, back to stand; only rows with plain results carry a typed phase.
  directed_row_t dir_rows [N_DIRECTED] = '{
    '{CMD_STOP,   16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b1, PH_STAND},
    '{CMD_UNUSED, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 1'b1, PH_STAND},
    '{CMD_FWD,    16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b1, PH_SHIFT_L},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'd0,     1'b1, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd12345, 16'd0,     1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'd299,   1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hAAAA,  16'h5555,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'h5555,  16'hAAAA,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'd0,     1'b0, 1'b1, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'hFFFF,  1'b0, 1'b1, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'd299,   16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 1'b1, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_FWD,    16'd300,   16'd0,     16'd0,     1'b1, 1'b0, 1'b0, PH_STAND},
    '{CMD_BACK,   16'd40000, 16'd100,   16'd100,   1'b0, 1'b1, 1'b0, PH_STAND},
    '{CMD_TURN_L, 16'hFFFF,  16'hFFFF,  16'd0,     1'b1, 1'b1, 1'b0, PH_STAND},
    '{CMD_TURN_R, 16'hFFFF,  16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, PH_STAND},
    '{CMD_STOP,   16'hFFFF,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, PH_STAND}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint slew(longint cur, longint tgt, longint lim);
    longint d;
    d = tgt - cur;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return cur + d;
  endfunction

  // Advance the gait state by one tick and return the pose it reports.
  function automatic gait_result_t next_gait_pose(gait_tick_t t);
    longint       stand, lift, sl, turn, tilt, half_sl, half_turn, llim, alim, nt;
    longint       tgt_len [4];
    longint       tgt_ang [4];
    bit           moving;
    gait_result_t r;
    stand     = -longint'(cfg_stand);
    lift      = stand + longint'(cfg_clear);
    tilt      = longint'(cfg_tilt);
    sl        = 0;
    turn      = 0;
    moving    = 1'b1;
    llim      = longint'(t.dt_us);
    alim      = longint'(t.dt_us) * longint'(ANG_RATE);
    case (t.cmd)
      CMD_FWD:    sl = longint'(cfg_len);
      CMD_BACK:   sl = -longint'(cfg_len);
      CMD_TURN_L: turn = -longint'(cfg_turn);
      CMD_TURN_R: turn = longint'(cfg_turn);
      default:    moving = 1'b0;
    endcase
    // signed division truncates toward zero, as the halved targets need
    half_sl   = sl / 2;
    half_turn = turn / 2;
    tgt_len   = '{0, stand, 0, stand};
    tgt_ang   = '{0, 0, 0, 0};
    if (moving) begin
      nt = longint'(model_timer) + longint'(t.dt_us) * longint'(cfg_speed);
      model_timer = (nt > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : nt[31:0];
      case (model_phase)
        PH_SHIFT_L: begin
          tgt_ang[1] = tilt;      tgt_ang[3] = tilt;
          tgt_len[0] = half_sl;   tgt_len[2] = -half_sl;
          tgt_ang[0] = half_turn; tgt_ang[2] = half_turn;
          if (model_timer > T_SHORT && t.right_force < cfg_rel) begin
            model_phase = PH_SWING_R;
            model_timer = '0;
          end
        end
        PH_SWING_R: begin
          tgt_ang[1] = tilt;      tgt_ang[3] = tilt;
          tgt_len[0] = -half_sl;  tgt_len[2] = sl;
          tgt_ang[2] = turn;      tgt_len[3] = lift;
          if (model_timer > T_SHORT) begin
            model_phase = PH_DROP_R;
            model_timer = '0;
          end
        end
        PH_DROP_R: begin
          tgt_ang[1] = tilt;      tgt_ang[3] = tilt;
          tgt_len[0] = -half_sl;  tgt_len[2] = sl;
          tgt_ang[2] = turn;
          if (t.right_grounded || model_timer > T_LONG) begin
            model_phase = PH_SHIFT_R;
            model_timer = '0;
          end
        end
        PH_SHIFT_R: begin
          tgt_ang[1] = -tilt;     tgt_ang[3] = -tilt;
          tgt_len[0] = -half_sl;  tgt_len[2] = half_sl;
          tgt_ang[0] = half_turn; tgt_ang[2] = half_turn;
          if (model_timer > T_SHORT && t.left_force < cfg_rel) begin
            model_phase = PH_SWING_L;
            model_timer = '0;
          end
        end
        PH_SWING_L: begin
          tgt_ang[1] = -tilt;     tgt_ang[3] = -tilt;
          tgt_len[2] = -half_sl;  tgt_len[0] = sl;
          tgt_ang[0] = turn;      tgt_len[1] = lift;
          if (model_timer > T_SHORT) begin
            model_phase = PH_DROP_L;
            model_timer = '0;
          end
        end
        PH_DROP_L: begin
          tgt_ang[1] = -tilt;     tgt_ang[3] = -tilt;
          tgt_len[2] = -half_sl;  tgt_len[0] = sl;
          tgt_ang[0] = turn;
          if (t.left_grounded || model_timer > T_LONG) begin
            model_phase = PH_SHIFT_L;
            model_timer = '0;
            model_steps = model_steps + 16'd1;
          end
        end
        default: begin
          // leaving stand: timer restarts, targets stay at the stand pose
          model_phase = PH_SHIFT_L;
          model_timer = '0;
        end
      endcase
    end else begin
      model_phase = PH_STAND;
    end
    for (int i = 0; i < 4; i++) begin
      model_len[i] = slew(model_len[i], tgt_len[i], llim);
      model_ang[i] = slew(model_ang[i], tgt_ang[i], alim);
    end
    r.lx    = model_len[0][LEN_W-1:0];
    r.ly    = model_len[1][LEN_W-1:0];
    r.rx    = model_len[2][LEN_W-1:0];
    r.ry    = model_len[3][LEN_W-1:0];
    r.lyaw  = model_ang[0][ANG_W-1:0];
    r.lroll = model_ang[1][ANG_W-1:0];
    r.ryaw  = model_ang[2][ANG_W-1:0];
    r.rroll = model_ang[3][ANG_W-1:0];
    r.phase = model_phase;
    r.steps = model_steps;
    return r;
  endfunction

  // Mostly runs of one walking command with loads that let the feet release.
  function automatic gait_tick_t random_tick();
    gait_tick_t t;
    int         cap;
    if (ep_left == 0) begin
      ep_left = $urandom_range(10, 60);
      if ($urandom_range(0, 7) == 0) ep_cmd = CMD_STOP;
      else ep_cmd = 3'($urandom_range(CMD_FWD, CMD_TURN_R));
    end
    ep_left--;
    t.cmd = ep_cmd;
    if ($urandom_range(0, 15) == 0) t.cmd = 3'($urandom);
    case ($urandom_range(0, 3))
      0:       t.dt_us = 16'($urandom);
      1:       t.dt_us = 16'hFFFF;
      2:       t.dt_us = 16'($urandom_range(0, 255));
      default: t.dt_us = 16'($urandom_range(20000, 65535));
    endcase
    cap = (cfg_rel == 0) ? 0 : ((cfg_rel > 17'd65536) ? 65535 : int'(cfg_rel) - 1);
    t.left_force     = $urandom_range(0, 1) ? 16'($urandom_range(0, cap)) : 16'($urandom);
    t.right_force    = $urandom_range(0, 1) ? 16'($urandom_range(0, cap)) : 16'($urandom);
    t.left_grounded  = ($urandom_range(0, 3) == 0);
    t.right_grounded = ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  function automatic reg_set_t random_setting();
    reg_set_t s;
    s[CFG_STAND_HEIGHT]  = 27'($urandom_range(0, 3000000));
    s[CFG_STEP_LENGTH]   = 27'($urandom_range(0, 1000000));
    s[CFG_STEP_CLEAR]    = 27'($urandom_range(0, 1000000));
    s[CFG_TURN_ANGLE]    = 27'($urandom_range(0, 90000000));
    s[CFG_BODY_TILT]     = 27'($urandom_range(0, 45000000));
    s[CFG_RELEASE_LEVEL] = ($urandom_range(0, 3) == 0) ? 27'($urandom_range(0, 98303))
                                                       : 27'($urandom_range(0, 4000));
    s[CFG_MOVE_SPEED]    = 27'($urandom_range(0, 255));
    return s;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result %0d %s: expected %0d, got %0d", result_index, name, want, got);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [26:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_STAND_HEIGHT:  cfg_stand = val[21:0];
      CFG_STEP_LENGTH:   cfg_len   = val[19:0];
      CFG_STEP_CLEAR:    cfg_clear = val[19:0];
      CFG_TURN_ANGLE:    cfg_turn  = val[26:0];
      CFG_BODY_TILT:     cfg_tilt  = val[25:0];
      CFG_RELEASE_LEVEL: cfg_rel   = val[16:0];
      CFG_MOVE_SPEED:    cfg_speed = val[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(reg_set_t s);
    for (int i = 0; i < 7; i++) write_reg(3'(i), s[i]);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Present one tick, wait for its transfer, then record what it should produce.
  task automatic send_tick(gait_tick_t t, logic typed, gait_result_t want);
    gait_result_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = next_gait_pose(t);
    pending_poses.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_poses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected", result_index);
      end else begin
        mon_want = pending_poses.pop_front();
        mon_got  = gait_result_t'(out_tdata[226:0]);
        check_field("left_x",       mon_want.lx,    mon_got.lx);
        check_field("left_height",  mon_want.ly,    mon_got.ly);
        check_field("left_yaw",     mon_want.lyaw,  mon_got.lyaw);
        check_field("left_roll",    mon_want.lroll, mon_got.lroll);
        check_field("right_x",      mon_want.rx,    mon_got.rx);
        check_field("right_height", mon_want.ry,    mon_got.ry);
        check_field("right_yaw",    mon_want.ryaw,  mon_got.ryaw);
        check_field("right_roll",   mon_want.rroll, mon_got.rroll);
        check_field("gait_phase",   mon_want.phase, mon_got.phase);
        check_field("steps_taken",  mon_want.steps, mon_got.steps);
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    reg_set_t     s;
    gait_tick_t   t;
    gait_result_t stand_pose;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    stand_pose    = '0;
    stand_pose.ly = HEIGHT_RST;
    stand_pose.ry = HEIGHT_RST;
    foreach (dir_rows[i]) begin
      t.cmd            = dir_rows[i].cmd;
      t.dt_us          = dir_rows[i].dt_us;
      t.left_force     = dir_rows[i].left_force;
      t.right_force    = dir_rows[i].right_force;
      t.left_grounded  = dir_rows[i].left_grounded;
      t.right_grounded = dir_rows[i].right_grounded;
      stand_pose.phase = dir_rows[i].want_phase;
      send_tick(t, dir_rows[i].typed, stand_pose);
    end
    drain_results();

    for (int k = 0; k < SETTINGS_RUN; k++) begin
      case (k)
        0: s = random_setting();
        1: s = '0;
        2: begin
          s[CFG_STAND_HEIGHT]  = 27'd3000000;
          s[CFG_STEP_LENGTH]   = 27'd1000000;
          s[CFG_STEP_CLEAR]    = 27'd1000000;
          s[CFG_TURN_ANGLE]    = 27'd90000000;
          s[CFG_BODY_TILT]     = 27'd45000000;
          s[CFG_RELEASE_LEVEL] = 27'd98303;
          s[CFG_MOVE_SPEED]    = 27'd255;
        end
        3: begin
          s = random_setting();
          s[CFG_RELEASE_LEVEL] = 27'd1;
          s[CFG_MOVE_SPEED]    = 27'd255;
        end
        4: s = random_setting();
        default: begin
          s[CFG_STAND_HEIGHT]  = 27'(STAND_HEIGHT_RST);
          s[CFG_STEP_LENGTH]   = 27'(STEP_LENGTH_RST);
          s[CFG_STEP_CLEAR]    = 27'(STEP_CLEAR_RST);
          s[CFG_TURN_ANGLE]    = 27'(TURN_ANGLE_RST);
          s[CFG_BODY_TILT]     = 27'(BODY_TILT_RST);
          s[CFG_RELEASE_LEVEL] = 27'(RELEASE_LEVEL_RST);
          s[CFG_MOVE_SPEED]    = 27'(MOVE_SPEED_RST);
        end
      endcase
      // a write past the register list must leave every setting alone
      if (k == 1) write_reg(CFG_UNUSED_IDX, 27'($urandom));
      apply_setting(s);
      idle_on = (k < 4);
      if (k == 3) begin
        // hold left shift under load until the timer pins at its ceiling
        t       = '0;
        t.cmd   = CMD_STOP;
        send_tick(t, 1'b0, '0);
        t.cmd   = CMD_FWD;
        send_tick(t, 1'b0, '0);
        t.dt_us       = 16'hFFFF;
        t.right_force = 16'hFFFF;
        repeat (HOLD_TICKS) send_tick(t, 1'b0, '0);
        t.dt_us = 16'd1000;
        send_tick(t, 1'b0, '0);
        // release succeeds only if the timer held instead of wrapping
        t.dt_us       = '0;
        t.right_force = '0;
        send_tick(t, 1'b0, '0);
      end else begin
        repeat (RANDOM_PER_SETTING) send_tick(random_tick(), 1'b0, '0);
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
